>>> hw/rtl/fptw_pkg.sv
// Shared types and constants for the four-level page table engine.
// Used by the channel interfaces and every module of the block.
package fptw_pkg;

  localparam int TABLE_POOL_DEF = 16;
  localparam int ENTRIES        = 512;
  localparam int IDX_W          = 9;
  localparam int ENTRY_W        = 64;
  localparam int FRAME_W        = 40;
  localparam int VA_W           = 64;
  localparam int PA_W           = 52;
  localparam int MODE_W         = 2;
  localparam int STATUS_W       = 2;
  localparam int CLR_W          = 9;

  localparam logic [MODE_W-1:0] MODE_MAP    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UNMAP  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_MAPPED = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EXHAUSTED  = 2'd2;

  // Flag bits of a parent entry that points to a table: user, read-write, present.
  localparam logic [2:0] LINK_FLAGS = 3'b111;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_RD,
    S_CHK,
    S_MOD,
    S_DECIDE,
    S_ALLOC_CLR,
    S_ALLOC_LINK,
    S_LEAF,
    S_DONE
  } state_t;

endpackage

>>> hw/rtl/fptw_if.sv
// Request and response channel interfaces of the page table engine.
// Depends on fptw_pkg for field widths.
interface fptw_req_if import fptw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [VA_W-1:0]   virt_addr;
  logic [PA_W-1:0]   phys_addr;
  logic              kernel_only;
  logic              writable;

  modport source (output valid, mode, virt_addr, phys_addr, kernel_only, writable,
                  input ready);
  modport sink (input valid, mode, virt_addr, phys_addr, kernel_only, writable,
                output ready);
endinterface

interface fptw_rsp_if import fptw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [PA_W-1:0]     phys_out;

  modport source (output valid, status, phys_out, input ready);
  modport sink (input valid, status, phys_out, output ready);
endinterface

>>> hw/rtl/fptw_mem.sv
// Table store: one write port and one read port with registered read data.
// Depends on fptw_pkg for the entry width.
module fptw_mem import fptw_pkg::*; #(
  parameter int DEPTH = TABLE_POOL_DEF * ENTRIES,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [ENTRY_W-1:0] wdata,
  input  logic               re,
  input  logic [AW-1:0]      raddr,
  output logic [ENTRY_W-1:0] rdata
);

  logic [ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/fptw_mod.sv
// Reduces a 40-bit frame offset modulo the pool size to a table number.
// Depends on fptw_pkg. A power-of-two pool takes the low offset bits; others go through a registered fold.
module fptw_mod import fptw_pkg::*; #(
  parameter int TABLE_POOL = TABLE_POOL_DEF,
  parameter int TW         = $clog2(TABLE_POOL)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [FRAME_W-1:0] value,
  output logic               done,
  output logic [TW-1:0]      rem
);

  localparam bit POW2 = (TABLE_POOL & (TABLE_POOL - 1)) == 0;

  generate
    if (POW2) begin : g_mask
      always_ff @(posedge clk) begin
        if (rst) begin
          done <= 1'b0;
        end else begin
          done <= start;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          rem <= value[TW-1:0];
        end
      end
    end else begin : g_fold
      // Each byte of the offset is weighted by its power of 256 modulo the pool
      // size; the small sum is then reduced with a reciprocal multiplication.
      localparam int CHUNKS = FRAME_W / 8;
      localparam int FW     = TW + 11;
      localparam int QW     = FW - TW + 1;
      localparam int SH     = FW + TW;
      localparam int PW     = 2 * FW + 2;
      localparam logic [FW+1:0] RECIP =
        (FW+2)'(((64'd1 << SH) + 64'(TABLE_POOL) - 64'd1) / 64'(TABLE_POOL));

      logic [FRAME_W-1:0] val;
      logic [FW-1:0]      term [CHUNKS];
      logic [FW-1:0]      fold_sum;
      logic [FW-1:0]      fold;
      logic [FW-1:0]      fold_d;
      logic [PW-1:0]      prod;
      logic [QW-1:0]      quot;
      logic [FW-1:0]      back;
      logic               stage1, stage2, stage3;

      for (genvar i = 0; i < CHUNKS; i++) begin : g_chunk
        localparam logic [TW-1:0] WGT = TW'((64'd1 << (8 * i)) % 64'(TABLE_POOL));
        assign term[i] = FW'(val[8*i +: 8]) * FW'(WGT);
      end

      always_comb begin
        fold_sum = '0;
        for (int i = 0; i < CHUNKS; i++) begin
          fold_sum = fold_sum + term[i];
        end
      end

      assign prod = PW'(fold) * PW'(RECIP);
      assign back = fold_d - FW'(quot) * FW'(TABLE_POOL);

      always_ff @(posedge clk) begin
        if (rst) begin
          stage1 <= 1'b0;
          stage2 <= 1'b0;
          stage3 <= 1'b0;
          done   <= 1'b0;
        end else begin
          stage1 <= start;
          stage2 <= stage1;
          stage3 <= stage2;
          done   <= stage3;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          val <= value;
        end
        if (stage1) begin
          fold <= fold_sum;
        end
        if (stage2) begin
          fold_d <= fold;
          quot   <= prod[SH +: QW];
        end
        if (stage3) begin
          rem <= back[TW-1:0];
        end
      end
    end
  endgenerate

endmodule

>>> hw/rtl/four_level_page_table_engine.sv
// Top level of the four-level page table engine: walk and allocate sequencer.
// Depends on fptw_pkg, fptw_if, fptw_mem and fptw_mod.
//
//   channel  dir  handshake      content
//   req      in   valid/ready    mode, virt_addr, phys_addr, kernel_only, writable
//   rsp      out  valid/ready    status, phys_out
//   cfg      in   cfg_wen        cfg_wdata[51:12] -> pool_frame
//
// After reset the root table is cleared, one entry a cycle, over its 512 entries.
// A request walks each upper level through read, check and reduce steps; the reduce
// step waits for fptw_mod, which takes longer when the pool is not a power of two.
// Each table that map or unmap allocates is cleared first: the clear sweeps its
// 512 entries through the single write port. One request is in work at a time;
// a new request is taken while the previous response waits in the output register.
module four_level_page_table_engine import fptw_pkg::*; #(
  parameter int TABLE_POOL = TABLE_POOL_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic [PA_W-1:0]      cfg_wdata,
  fptw_req_if.sink             req,
  fptw_rsp_if.source           rsp
);

  localparam int TW    = $clog2(TABLE_POOL);
  localparam int NW    = $clog2(TABLE_POOL + 1);
  localparam int DEPTH = TABLE_POOL * ENTRIES;
  localparam int AW    = TW + IDX_W;
  localparam logic [NW-1:0] POOL_N = NW'(TABLE_POOL);

  state_t state, state_next;

  logic [FRAME_W-1:0] pool_frame;
  logic [MODE_W-1:0]  mode_r;
  logic [IDX_W-1:0]   idx [4];
  logic [ENTRY_W-1:0] leaf_r;
  logic [1:0]         lvl;
  logic [TW-1:0]      tbl;
  logic [NW-1:0]      nft;
  logic [CLR_W-1:0]   clr_cnt;
  logic [STATUS_W-1:0] res_status;
  logic [PA_W-1:0]     res_phys;
  logic                rsp_valid;
  logic [STATUS_W-1:0] rsp_status;
  logic [PA_W-1:0]     rsp_phys;

  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [ENTRY_W-1:0] mem_wdata, mem_rdata;
  logic               mod_start, mod_done;
  logic [TW-1:0]      mod_rem;

  logic [FRAME_W-1:0] rd_frame;
  logic               rd_missing;
  logic [FRAME_W-1:0] new_frame;
  logic [NW-1:0]      left;
  logic               exhausted;
  logic               out_free;
  logic               clr_last;
  logic               accept;

  assign rd_frame   = mem_rdata[51:12];
  assign rd_missing = (rd_frame == '0);
  assign new_frame  = pool_frame + {{(FRAME_W-NW){1'b0}}, nft};
  assign left       = (nft < POOL_N) ? (POOL_N - nft) : '0;
  // Levels still missing below the first absent one: 3 - lvl.
  assign exhausted  = ({{(NW-2){1'b0}}, 2'd3 - lvl} > left);
  assign out_free   = !rsp_valid || rsp.ready;
  assign clr_last   = (clr_cnt == CLR_W'(ENTRIES - 1));
  assign accept     = req.valid && req.ready;

  assign rsp.valid    = rsp_valid;
  assign rsp.status   = rsp_status;
  assign rsp.phys_out = rsp_phys;

  fptw_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  fptw_mod #(.TABLE_POOL(TABLE_POOL), .TW(TW)) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .value (rd_frame - pool_frame),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_INIT: begin
        if (clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req.valid) state_next = S_RD;
      end
      S_RD: begin
        state_next = S_CHK;
      end
      S_CHK: begin
        if (lvl == 2'd3) state_next = S_DONE;
        else if (rd_missing) state_next = S_DECIDE;
        else state_next = S_MOD;
      end
      S_MOD: begin
        if (mod_done) state_next = (lvl == 2'd2) ? S_DECIDE : S_RD;
      end
      S_DECIDE: begin
        if (mode_r == MODE_LOOKUP) begin
          state_next = (lvl == 2'd3) ? S_RD : S_DONE;
        end else if (mode_r == MODE_MAP || mode_r == MODE_UNMAP) begin
          if (exhausted) state_next = S_DONE;
          else if (lvl == 2'd3) state_next = S_LEAF;
          else state_next = S_ALLOC_CLR;
        end else begin
          state_next = S_DONE;
        end
      end
      S_ALLOC_CLR: begin
        if (clr_last) state_next = S_ALLOC_LINK;
      end
      S_ALLOC_LINK: begin
        state_next = (lvl == 2'd2) ? S_LEAF : S_ALLOC_CLR;
      end
      S_LEAF: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = {tbl, idx[lvl]};
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = {tbl, idx[lvl]};
    mod_start = 1'b0;
    case (state)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = {TW'(0), clr_cnt};
      end
      S_IDLE: begin
        req.ready = 1'b1;
      end
      S_RD: begin
        mem_re = 1'b1;
      end
      S_CHK: begin
        mod_start = (lvl != 2'd3) && !rd_missing;
      end
      S_ALLOC_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = {nft[TW-1:0], clr_cnt};
      end
      S_ALLOC_LINK: begin
        mem_we    = 1'b1;
        mem_wdata = {12'b0, new_frame, 9'b0, LINK_FLAGS};
      end
      S_LEAF: begin
        mem_we    = 1'b1;
        mem_wdata = leaf_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      pool_frame <= '0;
      nft        <= NW'(1);
      clr_cnt    <= '0;
      lvl        <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        pool_frame <= cfg_wdata[51:12];
      end
      if (state == S_INIT || state == S_ALLOC_CLR) begin
        clr_cnt <= clr_cnt + CLR_W'(1);
      end
      if (accept) begin
        lvl <= '0;
      end else if (state == S_MOD && mod_done) begin
        lvl <= lvl + 2'd1;
      end else if (state == S_ALLOC_LINK) begin
        lvl <= lvl + 2'd1;
        nft <= nft + NW'(1);
      end
      if (state == S_DONE && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r     <= req.mode;
      idx[0]     <= req.virt_addr[47:39];
      idx[1]     <= req.virt_addr[38:30];
      idx[2]     <= req.virt_addr[29:21];
      idx[3]     <= req.virt_addr[20:12];
      tbl        <= '0;
      res_status <= STAT_OK;
      res_phys   <= '0;
      if (req.mode == MODE_MAP) begin
        leaf_r <= {12'b0, req.phys_addr[51:12], 9'b0, !req.kernel_only, req.writable, 1'b1};
      end else begin
        leaf_r <= '0;
      end
    end
    case (state)
      S_CHK: begin
        if (lvl == 2'd3) begin
          if (mem_rdata[0]) res_phys <= {rd_frame, 12'b0};
          else res_status <= STAT_NOT_MAPPED;
        end
      end
      S_MOD: begin
        if (mod_done) tbl <= mod_rem;
      end
      S_DECIDE: begin
        if (mode_r == MODE_LOOKUP) begin
          if (lvl != 2'd3) res_status <= STAT_NOT_MAPPED;
        end else if (mode_r == MODE_MAP || mode_r == MODE_UNMAP) begin
          if (exhausted) res_status <= STAT_EXHAUSTED;
        end
      end
      S_ALLOC_LINK: begin
        tbl <= nft[TW-1:0];
      end
      S_DONE: begin
        if (out_free) begin
          rsp_status <= res_status;
          rsp_phys   <= res_phys;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for four_level_page_table_engine: map, unmap, lookup and
// unused-mode requests against a mirrored page table, with random idling on both channels.
// Depends on fptw_pkg, the fptw_req_if/fptw_rsp_if interfaces and the RTL.
module testbench;
  import fptw_pkg::*;

  localparam int POOL = TABLE_POOL_DEF;
  localparam int PHASE_ITEMS = 495;
  localparam logic [ENTRY_W-1:0] FRAME_BITS = 64'h000F_FFFF_FFFF_F000;
  localparam logic [ENTRY_W-1:0] PTE_PRESENT = 64'h1;
  localparam logic [ENTRY_W-1:0] PTE_RW = 64'h2;
  localparam logic [ENTRY_W-1:0] PTE_USER = 64'h4;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [VA_W-1:0]   virt_addr;
    logic [PA_W-1:0]   phys_addr;
    logic              kernel_only;
    logic              writable;
  } page_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PA_W-1:0]     phys_out;
  } page_rsp_t;

  logic clk;
  logic rst;
  logic cfg_wen;
  logic [PA_W-1:0] cfg_wdata;

  fptw_req_if req_ch();
  fptw_rsp_if rsp_ch();

  four_level_page_table_engine dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // Mirror of the table pool, the allocation counter and the pool base.
  logic [ENTRY_W-1:0] pt_mirror [POOL*ENTRIES];
  int next_table;
  logic [PA_W-1:0] base_mirror;

  page_req_t pending_reqs[$];
  page_rsp_t expected_rsps[$];

  int err_count = 0;
  int n_map = 0, n_unmap = 0, n_lookup = 0, n_unused = 0, n_settings = 0;
  int n_ok = 0, n_not_mapped = 0, n_exhausted = 0;

  int req_gap, rsp_stall, rsp_wait;
  bit req_calm = 0, rsp_calm = 0;
  page_req_t taken_req, next_req;
  page_rsp_t seen_rsp, wanted_rsp;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int slot_of(int t, logic [IDX_W-1:0] i);
    return (t % POOL) * ENTRIES + int'(i);
  endfunction

  function automatic logic [ENTRY_W-1:0] frame_of_table(int t);
    logic [ENTRY_W-1:0] b;
    b = {12'h0, base_mirror} & FRAME_BITS;
    return (b + (64'(t) << 12)) & FRAME_BITS;
  endfunction

  function automatic int table_of_entry(logic [ENTRY_W-1:0] e);
    logic [ENTRY_W-1:0] d;
    d = ((e & FRAME_BITS) - ({12'h0, base_mirror} & FRAME_BITS)) >> 12;
    d &= 64'h0000_00FF_FFFF_FFFF;
    return int'(d % 64'(POOL));
  endfunction

  // Walks the mirrored tables, allocating and writing as the block would.
  function automatic page_rsp_t page_walk_predict(page_req_t r);
    logic [VA_W-1:0] va;
    logic [ENTRY_W-1:0] leaf;
    logic [IDX_W-1:0] idx [4];
    int t, depth, needed, left, n, l, j;
    page_rsp_t res;
    res = '0;
    res.status = STAT_OK;
    va = {16'h0, r.virt_addr[47:0]};
    for (l = 0; l < 4; l++)
      idx[l] = va[(39 - 9 * l) +: 9];
    t = 0;
    depth = 0;
    while (depth < 3 && (pt_mirror[slot_of(t, idx[depth])] & FRAME_BITS) != 0) begin
      t = table_of_entry(pt_mirror[slot_of(t, idx[depth])]);
      depth++;
    end
    if (r.mode == MODE_LOOKUP) begin
      if (depth < 3) begin
        res.status = STAT_NOT_MAPPED;
      end else begin
        leaf = pt_mirror[slot_of(t, idx[3])];
        if (leaf[0])
          res.phys_out = {leaf[51:12], 12'h0};
        else
          res.status = STAT_NOT_MAPPED;
      end
    end else if (r.mode == MODE_MAP || r.mode == MODE_UNMAP) begin
      needed = 3 - depth;
      left = (next_table < POOL) ? POOL - next_table : 0;
      if (needed > left) begin
        res.status = STAT_EXHAUSTED;
      end else begin
        for (l = depth; l < 3; l++) begin
          n = next_table;
          next_table++;
          for (j = 0; j < ENTRIES; j++)
            pt_mirror[slot_of(n, j[IDX_W-1:0])] = '0;
          pt_mirror[slot_of(t, idx[l])] = frame_of_table(n) | {61'h0, LINK_FLAGS};
          t = n;
        end
        leaf = '0;
        if (r.mode == MODE_MAP) begin
          leaf = ({12'h0, r.phys_addr} & FRAME_BITS) | PTE_PRESENT;
          if (!r.kernel_only)
            leaf |= PTE_USER;
          if (r.writable)
            leaf |= PTE_RW;
        end
        pt_mirror[slot_of(t, idx[3])] = leaf;
      end
    end
    return res;
  endfunction

  function automatic int draw_gap(inout bit calm);
    if ($urandom_range(0, 39) == 0)
      calm = !calm;
    return calm ? 0 : int'($urandom_range(0, 14));
  endfunction

  function automatic logic [PA_W-1:0] rand_pa();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[PA_W-1:0];
  endfunction

  // Upper-level indices (L1, L2, L3) of the paths the traffic concentrates on.
  // Some share upper tables so that allocations of one, two and three tables occur.
  function automatic logic [26:0] path_prefix(int k);
    case (k)
      0: return {9'd0, 9'd0, 9'd0};
      1: return {9'd511, 9'd511, 9'd511};
      2: return {9'd1, 9'd0, 9'd0};
      3: return {9'd0, 9'd0, 9'd5};
      4: return {9'd2, 9'd7, 9'd9};
      5: return {9'd3, 9'd1, 9'd1};
      6: return {9'd0, 9'd300, 9'd17};
      default: return {9'd4, 9'd4, 9'd4};
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] leaf_pick(int k);
    case (k)
      0: return 9'd0;
      1: return 9'd1;
      2: return 9'd2;
      3: return 9'd7;
      4: return 9'd255;
      5: return 9'd256;
      6: return 9'd510;
      default: return 9'd511;
    endcase
  endfunction

  function automatic page_req_t mk_req(logic [MODE_W-1:0] mode, logic [VA_W-1:0] va,
                                       logic [PA_W-1:0] pa, logic kern, logic wr);
    page_req_t r;
    r.mode = mode;
    r.virt_addr = va;
    r.phys_addr = pa;
    r.kernel_only = kern;
    r.writable = wr;
    return r;
  endfunction

  function automatic page_req_t make_random_req();
    int pick;
    logic [MODE_W-1:0] mode;
    logic [VA_W-1:0] va;
    logic [IDX_W-1:0] leaf;
    pick = $urandom_range(0, 99);
    if (pick < 40)
      mode = MODE_MAP;
    else if (pick < 60)
      mode = MODE_UNMAP;
    else if (pick < 98)
      mode = MODE_LOOKUP;
    else
      mode = MODE_UNUSED;
    if ($urandom_range(0, 9) == 0) begin
      // Stray address, almost always on a missing path.
      va = {$urandom, $urandom};
    end else begin
      leaf = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511))
                                         : leaf_pick($urandom_range(0, 7));
      va = {16'($urandom), path_prefix($urandom_range(0, 7)), leaf, 12'($urandom)};
    end
    return mk_req(mode, va, rand_pa(), 1'($urandom), 1'($urandom));
  endfunction

  task automatic wait_idle();
    @(posedge clk);
    while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || req_ch.valid)
      @(posedge clk);
  endtask

  task automatic set_pool_base(input logic [PA_W-1:0] v);
    wait_idle();
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    base_mirror = v;
    n_settings++;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  // Request driver: takes the next pending request after a random gap.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_gap <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        taken_req = {req_ch.mode, req_ch.virt_addr, req_ch.phys_addr,
                     req_ch.kernel_only, req_ch.writable};
        expected_rsps.push_back(page_walk_predict(taken_req));
        case (taken_req.mode)
          MODE_MAP: n_map++;
          MODE_UNMAP: n_unmap++;
          MODE_LOOKUP: n_lookup++;
          default: n_unused++;
        endcase
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (req_gap > 0) begin
          req_gap <= req_gap - 1;
          req_ch.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          next_req = pending_reqs.pop_front();
          req_ch.mode <= next_req.mode;
          req_ch.virt_addr <= next_req.virt_addr;
          req_ch.phys_addr <= next_req.phys_addr;
          req_ch.kernel_only <= next_req.kernel_only;
          req_ch.writable <= next_req.writable;
          req_ch.valid <= 1'b1;
          req_gap <= draw_gap(req_calm);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor: checks each response and then stalls for a random time.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rsp_stall <= 0;
    end else if (rsp_ch.valid && rsp_ch.ready) begin
      seen_rsp = {rsp_ch.status, rsp_ch.phys_out};
      if (expected_rsps.size() == 0) begin
        err_count++;
        $display("%0t: response with no request waiting, status %0d phys_out %h",
                 $time, seen_rsp.status, seen_rsp.phys_out);
      end else begin
        wanted_rsp = expected_rsps.pop_front();
        if (seen_rsp.status !== wanted_rsp.status) begin
          err_count++;
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, wanted_rsp.status, seen_rsp.status);
        end
        if (seen_rsp.phys_out !== wanted_rsp.phys_out) begin
          err_count++;
          $display("%0t: phys_out mismatch, expected %h, got %h",
                   $time, wanted_rsp.phys_out, seen_rsp.phys_out);
        end
      end
      case (seen_rsp.status)
        STAT_OK: n_ok++;
        STAT_NOT_MAPPED: n_not_mapped++;
        default: n_exhausted++;
      endcase
      rsp_wait = draw_gap(rsp_calm);
      rsp_stall <= rsp_wait;
      rsp_ch.ready <= (rsp_wait == 0);
    end else if (rsp_stall > 0) begin
      rsp_stall <= rsp_stall - 1;
      rsp_ch.ready <= (rsp_stall == 1);
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  initial begin
    int k, phase;
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.mode = MODE_MAP;
    req_ch.virt_addr = '0;
    req_ch.phys_addr = '0;
    req_ch.kernel_only = 1'b0;
    req_ch.writable = 1'b0;
    rsp_ch.ready = 1'b0;
    for (k = 0; k < POOL * ENTRIES; k++)
      pt_mirror[k] = '0;
    next_table = 1;
    base_mirror = '0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Before any table is handed out, any base is safe.
    set_pool_base(rand_pa());

    // Directed part: empty table, full and partial allocation, leaf flags,
    // unmap of an absent path, the unused mode and running out of tables.
    pending_reqs.push_back(mk_req(MODE_LOOKUP, 64'h0, '0, 1'b0, 1'b0));
    pending_reqs.push_back(mk_req(MODE_MAP, {16'hFFFF, path_prefix(0), 9'd0, 12'hABC},
                                  {PA_W{1'b1}}, 1'b0, 1'b1));
    pending_reqs.push_back(mk_req(MODE_LOOKUP, {16'h1234, path_prefix(0), 9'd0, 12'h0},
                                  '0, 1'b0, 1'b0));
    pending_reqs.push_back(mk_req(MODE_LOOKUP, {VA_W{1'b1}}, '0, 1'b0, 1'b0));
    pending_reqs.push_back(mk_req(MODE_MAP, {VA_W{1'b1}}, '0, 1'b1, 1'b0));
    pending_reqs.push_back(mk_req(MODE_LOOKUP, {VA_W{1'b1}}, '0, 1'b0, 1'b0));
    pending_reqs.push_back(mk_req(MODE_UNMAP, {VA_W{1'b1}}, rand_pa(), 1'b1, 1'b1));
    pending_reqs.push_back(mk_req(MODE_LOOKUP, {VA_W{1'b1}}, '0, 1'b0, 1'b0));
    pending_reqs.push_back(mk_req(MODE_UNMAP, {16'h0, path_prefix(2), 9'd3, 12'h0},
                                  '0, 1'b0, 1'b0));
    pending_reqs.push_back(mk_req(MODE_LOOKUP, {16'h0, path_prefix(2), 9'd3, 12'h0},
                                  '0, 1'b0, 1'b0));
    pending_reqs.push_back(mk_req(MODE_UNUSED, 64'h0, rand_pa(), 1'b0, 1'b1));
    pending_reqs.push_back(mk_req(MODE_MAP, {16'h0, path_prefix(3), 9'd511, 12'h0},
                                  52'hA_5A5A_5A5A_5FFF, 1'b1, 1'b1));
    pending_reqs.push_back(mk_req(MODE_MAP, {16'h0, path_prefix(4), 9'd256, 12'h0},
                                  rand_pa(), 1'b0, 1'b0));
    pending_reqs.push_back(mk_req(MODE_MAP, {16'h0, path_prefix(5), 9'd1, 12'h0},
                                  rand_pa(), 1'b0, 1'b1));
    pending_reqs.push_back(mk_req(MODE_MAP, {16'h0, path_prefix(6), 9'd2, 12'h0},
                                  rand_pa(), 1'b1, 1'b0));
    pending_reqs.push_back(mk_req(MODE_MAP, {16'h0, path_prefix(7), 9'd0, 12'h0},
                                  rand_pa(), 1'b0, 1'b1));
    pending_reqs.push_back(mk_req(MODE_UNMAP, {16'h0, path_prefix(5), 9'd1, 12'h0},
                                  '0, 1'b0, 1'b0));
    pending_reqs.push_back(mk_req(MODE_UNMAP, {16'h0, 9'd0, 9'd0, 9'd6, 9'd0, 12'h0},
                                  '0, 1'b0, 1'b0));
    pending_reqs.push_back(mk_req(MODE_LOOKUP, {16'h0, path_prefix(7), 9'd0, 12'h0},
                                  '0, 1'b0, 1'b0));
    pending_reqs.push_back(mk_req(MODE_MAP, {16'h0, path_prefix(0), 9'd7, 12'h0},
                                  rand_pa(), 1'b1, 1'b1));
    pending_reqs.push_back(mk_req(MODE_LOOKUP, {16'hFFFF, path_prefix(0), 9'd7, 12'h123},
                                  '0, 1'b0, 1'b0));
    pending_reqs.push_back(mk_req(MODE_LOOKUP, {16'h0, path_prefix(3), 9'd511, 12'h0},
                                  '0, 1'b0, 1'b0));
    pending_reqs.push_back(mk_req(MODE_LOOKUP, 64'h0, '0, 1'b0, 1'b0));

    // The pool is now fully handed out, so every table has been cleared and
    // any base keeps all walks on written entries.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        1: set_pool_base('0);
        2: set_pool_base({PA_W{1'b1}});
        3: set_pool_base(rand_pa());
        default: ;
      endcase
      for (k = 0; k < PHASE_ITEMS; k++)
        pending_reqs.push_back(make_random_req());
    end

    wait_idle();
    repeat (30) @(posedge clk);
    $display("Run covered %0d map, %0d unmap, %0d lookup and %0d unused-mode requests",
             n_map, n_unmap, n_lookup, n_unused);
    $display("under %0d pool base settings; responses: %0d ok, %0d not mapped, %0d exhausted",
             n_settings, n_ok, n_not_mapped, n_exhausted);
    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout: %0d requests pending, %0d responses outstanding",
             pending_reqs.size(), expected_rsps.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
